// ===== sv/irc_tok_pkg.sv =====
// Shared types and constants for the line tokenizer.
// Token kind codes, run state codes, byte codes and the token structs.
`default_nettype none

package irc_tok_pkg;

    // Width of the token length field on the result channel
    localparam int TOKEN_LEN_W = 10;

    // Token kinds
    localparam logic [2:0] K_COLON  = 3'd0;
    localparam logic [2:0] K_SPACES = 3'd1;
    localparam logic [2:0] K_EXCL   = 3'd2;
    localparam logic [2:0] K_AT     = 3'd3;
    localparam logic [2:0] K_CRLF   = 3'd4;
    localparam logic [2:0] K_STRING = 3'd5;
    localparam logic [2:0] K_ERROR  = 3'd6;

    // Pending run state
    localparam logic [1:0] P_NONE   = 2'd0;
    localparam logic [1:0] P_SPACES = 2'd1;
    localparam logic [1:0] P_STRING = 2'd2;
    localparam logic [1:0] P_CR     = 2'd3;

    // Byte codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;

    typedef struct packed {
        logic [2:0]             kind;
        logic [TOKEN_LEN_W-1:0] length;
        logic                   run_last;
        logic                   message_end;
    } t_token;

    // Up to two tokens caused by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_tok_pair;

endpackage

`default_nettype wire

// ===== sv/irc_tok_byte_if.sv =====
// Byte request channel: valid/ready handshake with the message byte and last flag.
// No dependencies.
`default_nettype none

interface irc_tok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== sv/irc_tok_token_if.sv =====
// Token request channel: valid/ready handshake with kind, length and end flags.
// No dependencies.
`default_nettype none

interface irc_tok_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic [9:0] token_length;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output token_kind, output token_length,
                    output run_last, output message_end, input ready);
    modport sink   (input valid, input token_kind, input token_length,
                    input run_last, input message_end, output ready);
endinterface

`default_nettype wire

// ===== sv/irc_tok_core.sv =====
// Tokenizer state and per-byte decode: pending run, failure flag, token pair.
// Depends on irc_tok_pkg.
`default_nettype none

module irc_tok_core
    import irc_tok_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 512
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_consume,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_tok_pair       o_pair
);

    localparam int LEN_BITS = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int LW = (LEN_BITS > TOKEN_LEN_W) ? LEN_BITS : TOKEN_LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LENGTH);

    logic [1:0]    r_pk;
    logic [LW-1:0] r_len;
    logic          r_fail;
    logic [1:0]    n_pk;
    logic [LW-1:0] n_len;
    logic          n_fail;

    t_token        flush_tok;
    logic          flush_v;
    logic [LW-1:0] grow_len;
    t_token        f_tok;
    t_token        m_tok;
    t_token        e_tok;
    logic          fv;
    logic          mv;
    logic          ev;

    // Decode one byte against the pending run
    always_comb begin
        flush_tok             = '0;
        flush_tok.kind        = (r_pk == P_SPACES) ? K_SPACES : K_STRING;
        flush_tok.length      = r_len[TOKEN_LEN_W-1:0];
        flush_v               = (r_pk == P_SPACES) || (r_pk == P_STRING);
        grow_len              = (r_len < MAX_LEN) ? r_len + 1'b1 : r_len;

        f_tok  = flush_tok;
        m_tok  = '0;
        e_tok  = '0;
        fv     = 1'b0;
        mv     = 1'b0;
        ev     = 1'b0;
        n_pk   = r_pk;
        n_len  = r_len;
        n_fail = r_fail;

        if (!r_fail) begin
            if (r_pk == P_CR) begin
                // CR then LF closes the line, anything else fails
                n_pk  = P_NONE;
                n_len = '0;
                mv    = 1'b1;
                if (i_byte == CH_LF) begin
                    m_tok.kind   = K_CRLF;
                    m_tok.length = TOKEN_LEN_W'(2);
                end else begin
                    m_tok.kind = K_ERROR;
                    n_fail     = 1'b1;
                end
            end else if (i_byte == CH_SPACE) begin
                if (r_pk == P_SPACES) begin
                    n_len = grow_len;
                end else begin
                    fv    = flush_v;
                    n_pk  = P_SPACES;
                    n_len = LW'(1);
                end
            end else if (i_byte == CH_CR) begin
                fv    = flush_v;
                n_pk  = P_CR;
                n_len = LW'(1);
            end else if (i_byte == CH_LF) begin
                // lone LF
                fv         = flush_v;
                mv         = 1'b1;
                m_tok.kind = K_ERROR;
                n_pk       = P_NONE;
                n_len      = '0;
                n_fail     = 1'b1;
            end else if (r_pk == P_STRING) begin
                n_len = grow_len;
            end else if (i_byte inside {CH_COLON, CH_EXCL, CH_AT}) begin
                fv           = flush_v;
                mv           = 1'b1;
                m_tok.length = TOKEN_LEN_W'(1);
                case (i_byte)
                    CH_COLON: m_tok.kind = K_COLON;
                    CH_EXCL:  m_tok.kind = K_EXCL;
                    default:  m_tok.kind = K_AT;
                endcase
                n_pk  = P_NONE;
                n_len = '0;
            end else begin
                fv    = flush_v;
                n_pk  = P_STRING;
                n_len = LW'(1);
            end
        end

        // Close the message: flush the run or fail on a trailing CR
        if (i_last) begin
            if (!n_fail) begin
                if (n_pk == P_CR) begin
                    ev         = 1'b1;
                    e_tok.kind = K_ERROR;
                end else begin
                    ev           = (n_pk == P_SPACES) || (n_pk == P_STRING);
                    e_tok.kind   = (n_pk == P_SPACES) ? K_SPACES : K_STRING;
                    e_tok.length = n_len[TOKEN_LEN_W-1:0];
                end
            end
            n_pk   = P_NONE;
            n_len  = '0;
            n_fail = 1'b0;
        end
    end

    // Pack the tokens in order and mark the last one
    always_comb begin
        o_pair       = '0;
        o_pair.count = {1'b0, fv} + {1'b0, mv} + {1'b0, ev};
        if (fv) begin
            o_pair.tok0 = f_tok;
            o_pair.tok1 = mv ? m_tok : e_tok;
        end else if (mv) begin
            o_pair.tok0 = m_tok;
            o_pair.tok1 = e_tok;
        end else begin
            o_pair.tok0 = e_tok;
        end
        if (o_pair.count == 2'd2) begin
            o_pair.tok1.run_last    = 1'b1;
            o_pair.tok1.message_end = i_last;
        end else begin
            o_pair.tok0.run_last    = 1'b1;
            o_pair.tok0.message_end = i_last;
        end
    end

    // Advance the run state on each consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk   <= P_NONE;
            r_len  <= '0;
            r_fail <= 1'b0;
        end else if (i_consume) begin
            r_pk   <= n_pk;
            r_len  <= n_len;
            r_fail <= n_fail;
        end
    end

endmodule

`default_nettype wire

// ===== sv/irc_tok_queue.sv =====
// Four-entry token queue that takes up to two tokens a cycle and issues one.
// Depends on irc_tok_pkg and irc_tok_token_if.
`default_nettype none

module irc_tok_queue
    import irc_tok_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [1:0]  i_push_cnt,
    input  t_token           i_tok0,
    input  t_token           i_tok1,
    output logic             o_room,
    irc_tok_token_if.source  o_tokens
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_token        r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_count;
    logic          pop;
    t_token        head;

    assign pop    = o_tokens.valid && o_tokens.ready;
    assign o_room = r_count <= (AW+1)'(DEPTH - 2);
    assign head   = r_mem[r_rp];

    // Drive the head entry
    assign o_tokens.valid        = r_count != '0;
    assign o_tokens.token_kind   = head.kind;
    assign o_tokens.token_length = head.length;
    assign o_tokens.run_last     = head.run_last;
    assign o_tokens.message_end  = head.message_end;

    // Store incoming tokens
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_tok0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_tok1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + AW'(i_push_cnt);
            r_rp    <= r_rp + AW'(pop);
            r_count <= r_count + (AW+1)'(i_push_cnt) - (AW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== sv/irc_line_tokenizer.sv =====
// Line tokenizer: one message byte a cycle in while the token queue has room, kind/length tokens out.
// Byte path: input register, core decode, token queue; the queue head drives the output.
// Throughput: one byte per cycle while the queue holds two tokens or fewer; a four-entry
// token queue absorbs bytes that yield two tokens, and input stalls when it holds more.
// Reset: synchronous active-low i_rst_n clears the input stage, run state and queue.
// Depends on irc_tok_pkg, irc_tok_byte_if, irc_tok_token_if, irc_tok_core, irc_tok_queue.
`default_nettype none

module irc_line_tokenizer
    import irc_tok_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 512
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    irc_tok_byte_if.sink    i_bytes,
    irc_tok_token_if.source o_tokens
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       consume;
    logic       room;
    logic [1:0] push_cnt;
    t_tok_pair  pair;

    assign consume       = r_in_valid && room;
    assign i_bytes.ready = !r_in_valid || consume;
    assign push_cnt      = consume ? pair.count : 2'd0;

    // Hold the input byte until the queue has room for its tokens
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_bytes.ready) begin
            r_in_valid <= i_bytes.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bytes.valid && i_bytes.ready) begin
            r_in_byte <= i_bytes.in_byte;
            r_in_last <= i_bytes.in_last;
        end
    end

    irc_tok_core #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_pair    (pair)
    );

    irc_tok_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_tok0     (pair.tok0),
        .i_tok1     (pair.tok1),
        .o_room     (room),
        .o_tokens   (o_tokens)
    );

endmodule

`default_nettype wire
